// ----- sv/bfrm_pkg.sv -----
// Shared types, constants and arithmetic helpers of the boresight frame rotation matrix unit.
`default_nettype none
package bfrm_pkg;

	localparam int unsigned FULL_TURN      = 368640;
	localparam int unsigned QUARTER_TURN   = 92160;
	localparam int unsigned CORDIC_STEPS   = 31;
	localparam int unsigned NORM_LAT       = 69;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [30:0]        RAD_SCALE   = 31'd1199381129;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [31:0]        RATIO_RESET = 32'd1774546269;

	// Angle split into quadrant and remainder inside the quadrant
	typedef struct packed {
		logic [1:0]  quad;
		logic [16:0] rem;
	} angle_t;

	// Classified item handed from front to back
	typedef struct packed {
		angle_t theta;
		angle_t phi;
	} item_t;

	// Arctangent of 2^-i in Q2.30 radians
	function automatic logic [31:0] atan_q30(input int unsigned i);
		logic [31:0] r;
		case (i)
			0:  r = 32'h3243F6A8;
			1:  r = 32'h1DAC6705;
			2:  r = 32'h0FADBAFC;
			3:  r = 32'h07F56EA6;
			4:  r = 32'h03FEAB76;
			5:  r = 32'h01FFD55B;
			6:  r = 32'h00FFFAAA;
			7:  r = 32'h007FFF55;
			8:  r = 32'h003FFFEA;
			9:  r = 32'h001FFFFD;
			10: r = 32'h000FFFFF;
			11: r = 32'h0007FFFF;
			12: r = 32'h0003FFFF;
			13: r = 32'h0001FFFF;
			14: r = 32'h0000FFFF;
			15: r = 32'h00007FFF;
			16: r = 32'h00003FFF;
			17: r = 32'h00001FFF;
			18: r = 32'h00000FFF;
			19: r = 32'h000007FF;
			20: r = 32'h000003FF;
			21: r = 32'h000001FF;
			22: r = 32'h000000FF;
			23: r = 32'h0000007F;
			24: r = 32'h0000003F;
			25: r = 32'h0000001F;
			26: r = 32'h0000000F;
			27: r = 32'h00000008;
			28: r = 32'h00000004;
			29: r = 32'h00000002;
			30: r = 32'h00000001;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	// Magnitude of a Q1.30 value bounded by one
	function automatic logic [30:0] mag31(input logic signed [31:0] a);
		logic [31:0] t;
		t = a[31] ? 32'(-a) : 32'(a);
		return t[30:0];
	endfunction

	// Round a Q2.60 magnitude product half away from zero to Q1.30
	function automatic logic [31:0] rnd_q30(input logic [61:0] m);
		logic [62:0] t;
		t = 63'(m) + (63'd1 << 29);
		return 32'(t[62:30]);
	endfunction

	// Saturate to plus or minus one in Q1.30
	function automatic logic signed [31:0] clamp_q30(input logic signed [35:0] a);
		logic signed [31:0] r;
		if (a > 36'sd1073741824) begin
			r = 32'sd1073741824;
		end else if (a < -36'sd1073741824) begin
			r = -32'sd1073741824;
		end else begin
			r = 32'(a);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- sv/bfrm_front.sv -----
// Front end: takes angle triples, reduces them to quadrant and remainder.
`default_nettype none
module bfrm_front
	import bfrm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic        q_full,
	output logic        push,
	output item_t       push_item
);

	logic signed [18:0] sat;
	logic signed [17:0] lat;
	logic signed [18:0] lon;
	logic signed [20:0] diff;
	logic [20:0]        phi_raw;
	logic [20:0]        th_raw;
	logic               vld_s1;
	item_t              item_s1;
	item_t              item_d;

	// Reduce an angle below four turns to one turn
	function automatic logic [18:0] reduce_turn(input logic [20:0] a);
		logic [20:0] r;
		if (a >= 21'(3 * FULL_TURN)) begin
			r = a - 21'(3 * FULL_TURN);
		end else if (a >= 21'(2 * FULL_TURN)) begin
			r = a - 21'(2 * FULL_TURN);
		end else if (a >= 21'(FULL_TURN)) begin
			r = a - 21'(FULL_TURN);
		end else begin
			r = a;
		end
		return 19'(r);
	endfunction

	// Split a turn into quadrant and remainder
	function automatic angle_t split_turn(input logic [18:0] a);
		angle_t r;
		if (a >= 19'(3 * QUARTER_TURN)) begin
			r.quad = 2'd3;
			r.rem  = 17'(a - 19'(3 * QUARTER_TURN));
		end else if (a >= 19'(2 * QUARTER_TURN)) begin
			r.quad = 2'd2;
			r.rem  = 17'(a - 19'(2 * QUARTER_TURN));
		end else if (a >= 19'(QUARTER_TURN)) begin
			r.quad = 2'd1;
			r.rem  = 17'(a - 19'(QUARTER_TURN));
		end else begin
			r.quad = 2'd0;
			r.rem  = 17'(a);
		end
		return r;
	endfunction

	assign sat     = s_tdata[18:0];
	assign lat     = s_tdata[36:19];
	assign lon     = s_tdata[55:37];
	assign diff    = 21'(lon) - 21'(sat);
	assign phi_raw = 21'(diff + 21'sd737280);
	assign th_raw  = 21'(21'(lat) + 21'sd368640);

	always_comb begin
		item_d.phi   = split_turn(reduce_turn(phi_raw));
		item_d.theta = split_turn(reduce_turn(th_raw));
	end

	// Hold the classified item until the queue takes it
	assign push      = vld_s1 && !q_full;
	assign s_tready  = !vld_s1 || push;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_d;
		end
	end

endmodule
`default_nettype wire

// ----- sv/bfrm_queue.sv -----
// Short queue of classified items between front and back.
`default_nettype none
module bfrm_queue
	import bfrm_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	output logic  not_empty,
	input  logic  pop,
	output item_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// Store the pushed item
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue count beyond depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("pop from empty queue");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count did not follow push");
`endif

endmodule
`default_nettype wire

// ----- sv/bfrm_cordic.sv -----
// Pipelined rotation-mode CORDIC giving cosine and sine of one angle.
`default_nettype none
module bfrm_cordic
	import bfrm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  angle_t             ang,
	output logic               out_valid,
	output logic signed [31:0] cos_o,
	output logic signed [31:0] sin_o
);

	localparam int N = CORDIC_STEPS;

	logic               vld_s  [0:N];
	logic signed [33:0] x_s    [0:N];
	logic signed [33:0] y_s    [0:N];
	logic signed [32:0] z_s    [0:N];
	logic [1:0]         quad_s [0:N];
	logic [47:0]        zprod;
	logic signed [31:0] xc;
	logic signed [31:0] yc;

	assign zprod = 48'(ang.rem) * 48'(RAD_SCALE);

	// Load the remainder as radians
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= CORDIC_GAIN;
			y_s[0]    <= '0;
			z_s[0]    <= $signed({1'b0, zprod[47:16]});
			quad_s[0] <= ang.quad;
		end
	end

	// One micro-rotation per stage
	for (genvar i = 0; i < N; i++) begin : g_step
		localparam logic signed [32:0] AT = $signed({1'b0, atan_q30(i)});
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - AT;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + AT;
				end
				quad_s[i+1] <= quad_s[i];
			end
		end
	end

	assign xc = clamp_q30(36'(x_s[N]));
	assign yc = clamp_q30(36'(y_s[N]));

	// Saturate and rotate into the quadrant
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (quad_s[N])
				2'd0: begin
					cos_o <= xc;
					sin_o <= yc;
				end
				2'd1: begin
					cos_o <= -yc;
					sin_o <= xc;
				end
				2'd2: begin
					cos_o <= -xc;
					sin_o <= -yc;
				end
				default: begin
					cos_o <= yc;
					sin_o <= -xc;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- sv/bfrm_norm.sv -----
// Vector normaliser: block scaling, square-root pipeline and divider lanes.
`default_nettype none
module bfrm_norm
	import bfrm_pkg::*;
#(
	parameter int K  = 3,
	parameter int VW = 36
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [VW-1:0] v [K],
	output logic                 out_valid,
	output logic signed [31:0]   u [K]
);

	localparam int TOPW = $clog2(VW);
	localparam int RS   = 32;
	localparam int DS   = 31;

	logic            vld_s1;
	logic [VW-1:0]   mag_s1 [K];
	logic            neg_s1 [K];
	logic [VW-1:0]   all_s1;
	logic [TOPW-1:0] top;
	logic [30:0]     shv [K];

	logic            vld_s2;
	logic [30:0]     m_s2 [K];
	logic            neg_s2 [K];
	logic            zero_s2;

	logic            vld_s3;
	logic [61:0]     sq_s3 [K];
	logic [30:0]     m_s3 [K];
	logic            neg_s3 [K];
	logic            zero_s3;

	logic            rt_vld_s  [0:RS];
	logic [63:0]     rt_rem_s  [0:RS];
	logic [63:0]     rt_res_s  [0:RS];
	logic [30:0]     rt_m_s    [0:RS][K];
	logic            rt_neg_s  [0:RS][K];
	logic            rt_zero_s [0:RS];

	logic            dv_vld_s  [0:DS];
	logic [31:0]     dv_d_s    [0:DS];
	logic [61:0]     dv_num_s  [0:DS][K];
	logic [31:0]     dv_rem_s  [0:DS][K];
	logic [30:0]     dv_q_s    [0:DS][K];
	logic            dv_neg_s  [0:DS][K];
	logic            dv_zero_s [0:DS];

	logic [61:0]     num0 [K];

	// Take magnitudes and their union
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		logic [VW-1:0] acc;
		logic [VW-1:0] mg;
		if (en) begin
			acc = '0;
			for (int k = 0; k < K; k++) begin
				mg        = v[k][VW-1] ? VW'(-v[k]) : VW'(v[k]);
				mag_s1[k] <= mg;
				neg_s1[k] <= v[k][VW-1];
				acc       = acc | mg;
			end
			all_s1 <= acc;
		end
	end

	// Find the top set bit and shift it to bit 30
	always_comb begin
		top = '0;
		for (int b = 0; b < VW; b++) begin
			if (all_s1[b]) begin
				top = TOPW'(b);
			end
		end
	end

	always_comb begin
		logic [63:0] ext;
		for (int k = 0; k < K; k++) begin
			ext = 64'(mag_s1[k]);
			if (32'(top) > 32'd30) begin
				shv[k] = 31'(ext >> (32'(top) - 32'd30));
			end else begin
				shv[k] = 31'(ext << (32'd30 - 32'(top)));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			rt_vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			rt_vld_s[0] <= vld_s3;
		end
	end

	// Scale, square and sum
	always_ff @(posedge clk) begin
		logic [63:0] sum;
		if (en) begin
			for (int k = 0; k < K; k++) begin
				m_s2[k]   <= shv[k];
				neg_s2[k] <= neg_s1[k];
				sq_s3[k]  <= 62'(m_s2[k]) * 62'(m_s2[k]);
				m_s3[k]   <= m_s2[k];
				neg_s3[k] <= neg_s2[k];
				rt_m_s[0][k]   <= m_s3[k];
				rt_neg_s[0][k] <= neg_s3[k];
			end
			zero_s2 <= (all_s1 == '0);
			zero_s3 <= zero_s2;
			sum = '0;
			for (int k = 0; k < K; k++) begin
				sum = sum + 64'(sq_s3[k]);
			end
			rt_rem_s[0]  <= sum;
			rt_res_s[0]  <= '0;
			rt_zero_s[0] <= zero_s3;
		end
	end

	// Square root, one result bit per stage
	for (genvar j = 0; j < RS; j++) begin : g_root
		localparam logic [63:0] BW = 64'd1 << (62 - 2 * j);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[j+1] <= 1'b0;
			end else if (en) begin
				rt_vld_s[j+1] <= rt_vld_s[j];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (rt_rem_s[j] >= rt_res_s[j] + BW) begin
					rt_rem_s[j+1] <= rt_rem_s[j] - (rt_res_s[j] + BW);
					rt_res_s[j+1] <= (rt_res_s[j] >> 1) + BW;
				end else begin
					rt_rem_s[j+1] <= rt_rem_s[j];
					rt_res_s[j+1] <= rt_res_s[j] >> 1;
				end
				for (int k = 0; k < K; k++) begin
					rt_m_s[j+1][k]   <= rt_m_s[j][k];
					rt_neg_s[j+1][k] <= rt_neg_s[j][k];
				end
				rt_zero_s[j+1] <= rt_zero_s[j];
			end
		end
	end

	// Form rounded dividends
	always_comb begin
		for (int k = 0; k < K; k++) begin
			num0[k] = 62'({rt_m_s[RS][k], 30'b0}) + 62'(rt_res_s[RS][31:1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else if (en) begin
			dv_vld_s[0] <= rt_vld_s[RS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_d_s[0]    <= rt_res_s[RS][31:0];
			dv_zero_s[0] <= rt_zero_s[RS];
			for (int k = 0; k < K; k++) begin
				dv_num_s[0][k] <= num0[k];
				dv_rem_s[0][k] <= 32'(num0[k][61:31]);
				dv_q_s[0][k]   <= '0;
				dv_neg_s[0][k] <= rt_neg_s[RS][k];
			end
		end
	end

	// Restoring division, one quotient bit per stage
	for (genvar s = 0; s < DS; s++) begin : g_div
		localparam int BI = DS - 1 - s;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[s+1] <= 1'b0;
			end else if (en) begin
				dv_vld_s[s+1] <= dv_vld_s[s];
			end
		end
		always_ff @(posedge clk) begin
			logic [32:0] sh;
			if (en) begin
				for (int k = 0; k < K; k++) begin
					sh = {dv_rem_s[s][k], dv_num_s[s][k][BI]};
					if (sh >= {1'b0, dv_d_s[s]}) begin
						dv_rem_s[s+1][k] <= 32'(sh - {1'b0, dv_d_s[s]});
						dv_q_s[s+1][k]   <= {dv_q_s[s][k][29:0], 1'b1};
					end else begin
						dv_rem_s[s+1][k] <= 32'(sh);
						dv_q_s[s+1][k]   <= {dv_q_s[s][k][29:0], 1'b0};
					end
					dv_num_s[s+1][k] <= dv_num_s[s][k];
					dv_neg_s[s+1][k] <= dv_neg_s[s][k];
				end
				dv_d_s[s+1]    <= dv_d_s[s];
				dv_zero_s[s+1] <= dv_zero_s[s];
			end
		end
	end

	// Restore signs; a zero vector gives zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_vld_s[DS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < K; k++) begin
				if (dv_zero_s[DS]) begin
					u[k] <= '0;
				end else if (dv_neg_s[DS][k]) begin
					u[k] <= -$signed({1'b0, dv_q_s[DS][k]});
				end else begin
					u[k] <= $signed({1'b0, dv_q_s[DS][k]});
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/bfrm_back.sv -----
// Back end: sine and cosine, boresight vector, two normalisations and cross products.
`default_nettype none
module bfrm_back
	import bfrm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  item_t        q_item,
	output logic         pop,
	input  logic [31:0]  ratio,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [255:0] m_tdata
);

	logic               en;
	logic               ct_vld;
	logic               cp_vld;
	logic signed [31:0] ct;
	logic signed [31:0] st;
	logic signed [31:0] cp;
	logic signed [31:0] sp;

	logic               vld_s1;
	logic [61:0]        pa_s1;
	logic [61:0]        pb_s1;
	logic               na_s1;
	logic               nb_s1;
	logic signed [31:0] st_s1;

	logic               vld_s2;
	logic signed [35:0] v_s2 [3];

	logic               n1_vld;
	logic signed [31:0] z [3];
	logic signed [31:0] w [2];
	logic [95:0]        zd_s [NORM_LAT];

	logic               n2_vld;
	logic signed [31:0] y [2];
	logic signed [31:0] zz [3];

	logic               vld_s3;
	logic [61:0]        p_s3 [4];
	logic               pn_s3 [4];
	logic signed [31:0] y_s3 [2];
	logic signed [31:0] z_s3 [3];

	logic signed [33:0] r_c [4];
	logic signed [35:0] res [3];

	// Whole back pipeline moves unless the result register is held
	assign en  = !m_tvalid || m_tready;
	assign pop = q_valid && en;

	bfrm_cordic u_cordic_theta (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (q_valid),
		.ang       (q_item.theta),
		.out_valid (ct_vld),
		.cos_o     (ct),
		.sin_o     (st)
	);

	bfrm_cordic u_cordic_phi (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (q_valid),
		.ang       (q_item.phi),
		.out_valid (cp_vld),
		.cos_o     (cp),
		.sin_o     (sp)
	);

	// Multiply cos theta by cos phi and sin phi
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= ct_vld && cp_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [32:0] ra;
		logic signed [32:0] rb;
		if (en) begin
			pa_s1 <= 62'(mag31(ct)) * 62'(mag31(cp));
			pb_s1 <= 62'(mag31(ct)) * 62'(mag31(sp));
			na_s1 <= ct[31] != cp[31];
			nb_s1 <= ct[31] != sp[31];
			st_s1 <= st;
			ra = $signed({1'b0, rnd_q30(pa_s1)});
			rb = $signed({1'b0, rnd_q30(pb_s1)});
			v_s2[0] <= (na_s1 ? -36'(ra) : 36'(ra)) - $signed({2'b00, ratio, 2'b00});
			v_s2[1] <= nb_s1 ? -36'(rb) : 36'(rb);
			v_s2[2] <= 36'(st_s1);
		end
	end

	bfrm_norm #(.K(3), .VW(36)) u_norm_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s2),
		.v         (v_s2),
		.out_valid (n1_vld),
		.u         (z)
	);

	// Z crossed with the pole axis
	assign w[0] = z[1];
	assign w[1] = -z[0];

	bfrm_norm #(.K(2), .VW(32)) u_norm_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (n1_vld),
		.v         (w),
		.out_valid (n2_vld),
		.u         (y)
	);

	// Delay Z alongside the second normalisation
	always_ff @(posedge clk) begin
		if (en) begin
			zd_s[0] <= {z[2], z[1], z[0]};
			for (int j = 1; j < NORM_LAT; j++) begin
				zd_s[j] <= zd_s[j-1];
			end
		end
	end

	assign zz[0] = zd_s[NORM_LAT-1][31:0];
	assign zz[1] = zd_s[NORM_LAT-1][63:32];
	assign zz[2] = zd_s[NORM_LAT-1][95:64];

	// Products of Y cross Z
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= n2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3[0]  <= 62'(mag31(y[1])) * 62'(mag31(zz[2]));
			p_s3[1]  <= 62'(mag31(y[0])) * 62'(mag31(zz[2]));
			p_s3[2]  <= 62'(mag31(y[0])) * 62'(mag31(zz[1]));
			p_s3[3]  <= 62'(mag31(y[1])) * 62'(mag31(zz[0]));
			pn_s3[0] <= y[1][31] != zz[2][31];
			pn_s3[1] <= y[0][31] != zz[2][31];
			pn_s3[2] <= y[0][31] != zz[1][31];
			pn_s3[3] <= y[1][31] != zz[0][31];
			y_s3     <= y;
			z_s3     <= zz;
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			r_c[k] = pn_s3[k] ? -$signed({2'b00, rnd_q30(p_s3[k])})
			                  : $signed({2'b00, rnd_q30(p_s3[k])});
		end
		res[0] = 36'(r_c[0]);
		res[1] = -36'(r_c[1]);
		res[2] = 36'(r_c[2]) - 36'(r_c[3]);
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {clamp_q30(36'(z_s3[2])), clamp_q30(36'(z_s3[1])),
			            clamp_q30(36'(z_s3[0])), clamp_q30(36'(y_s3[1])),
			            clamp_q30(36'(y_s3[0])), clamp_q30(res[2]),
			            clamp_q30(res[1]), clamp_q30(res[0])};
		end
	end

endmodule
`default_nettype wire

// ----- sv/boresight_frame_rotation_matrix_unit.sv -----
// Throughput: one item per cycle; the back pipeline advances whenever the result register
// is empty or being taken, and the front keeps filling the queue while the back is held.
// Most of the latency sits in the two normalisers: 32 square-root and 31 divide stages each.
// Reset clears all valid bits, the queue and restores orbit_radius_ratio to its reset value.
// Top level: configuration register, front end, item queue and back end.
`default_nettype none
module boresight_frame_rotation_matrix_unit
	import bfrm_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// sat_longitude[18:0], aim_latitude[36:19], aim_longitude[55:37]
	input  logic [55:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// x_axis_e1, x_axis_e2, x_axis_e3, y_axis_e1, y_axis_e2, z_axis_e1, z_axis_e2,
	// z_axis_e3: 32 bits each from bit 0 up
	output logic [255:0] m_tdata,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata
);

	logic [31:0] ratio_q;
	logic        push;
	item_t       push_item;
	logic        q_full;
	logic        q_valid;
	logic        pop;
	item_t       head;

	// Orbit radius ratio register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
		end else if (cfg_we) begin
			ratio_q <= cfg_wdata;
		end
	end

	bfrm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	bfrm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.not_empty (q_valid),
		.pop       (pop),
		.head      (head)
	);

	bfrm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (head),
		.pop      (pop),
		.ratio    (ratio_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire
